>>> rtl/shc_pkg.sv
`default_nettype none
package shc_pkg;

    localparam int DEG_W    = 3;
    localparam int ORD_W    = 4;
    localparam int COORD_W  = 24;
    localparam int RAD_W    = COORD_W - 1;
    localparam int OUT_W    = 24;
    localparam int OUT_FRAC = 20;
    localparam int K_FRAC   = 30;
    localparam int KQ_W     = 32;
    localparam int SEL_W    = 4;
    localparam int ST_W     = 2;

    // product and polynomial widths
    localparam int SQ_W  = 2 * COORD_W;
    localparam int T_W   = SQ_W + 3;
    localparam int TL_W  = 26;
    localparam int TH_W  = T_W - TL_W;
    localparam int PL_W  = COORD_W + TL_W + 1;
    localparam int PH_W  = COORD_W + TH_W;
    localparam int P_W   = 3 * COORD_W + 2;
    localparam int PM_W  = P_W - 1;
    localparam int RR_W  = 2 * RAD_W;
    localparam int RL_W  = 3 * RAD_W;

    // numerator split for the constant multiply
    localparam int PS_W  = 25;
    localparam int MP_W  = KQ_W + PS_W;
    localparam int N_W   = KQ_W + PM_W;
    localparam int DSH   = K_FRAC - OUT_FRAC;
    localparam int A_W   = N_W + 2;
    localparam int B_W   = RL_W + DSH + 1;
    localparam int Q_W   = OUT_W;

    // pipeline depths
    localparam int POLY_ST  = 5;
    localparam int SCALE_ST = 3;
    localparam int DIV_ST   = Q_W + 2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_UNSUP = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO  = 2'd2;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd3;

    // harmonic selector: l*l + l + m
    localparam logic [SEL_W-1:0] SEL_00  = 4'd0;
    localparam logic [SEL_W-1:0] SEL_1N1 = 4'd1;
    localparam logic [SEL_W-1:0] SEL_10  = 4'd2;
    localparam logic [SEL_W-1:0] SEL_1P1 = 4'd3;
    localparam logic [SEL_W-1:0] SEL_2N2 = 4'd4;
    localparam logic [SEL_W-1:0] SEL_2N1 = 4'd5;
    localparam logic [SEL_W-1:0] SEL_20  = 4'd6;
    localparam logic [SEL_W-1:0] SEL_2P1 = 4'd7;
    localparam logic [SEL_W-1:0] SEL_2P2 = 4'd8;
    localparam logic [SEL_W-1:0] SEL_3N3 = 4'd9;
    localparam logic [SEL_W-1:0] SEL_3N2 = 4'd10;
    localparam logic [SEL_W-1:0] SEL_3N1 = 4'd11;
    localparam logic [SEL_W-1:0] SEL_30  = 4'd12;
    localparam logic [SEL_W-1:0] SEL_3P1 = 4'd13;
    localparam logic [SEL_W-1:0] SEL_3P2 = 4'd14;
    localparam logic [SEL_W-1:0] SEL_3P3 = 4'd15;

    typedef struct packed {
        logic [ST_W-1:0] pre;
        logic            neg;
        logic [PM_W-1:0] pmag;
        logic [KQ_W-1:0] kq;
        logic [RL_W-1:0] rl;
    } t_poly_word;

    typedef struct packed {
        logic [ST_W-1:0] pre;
        logic            neg;
        logic [A_W-1:0]  a;
        logic [B_W-1:0]  b;
    } t_scale_word;

    typedef struct packed {
        logic [ST_W-1:0] pre;
        logic            neg;
        logic            ovf;
        logic [B_W-1:0]  b;
        logic [A_W-1:0]  rem;
        logic [Q_W-1:0]  q;
    } t_div_lane;

    function automatic logic [SEL_W-1:0] sel_of(input logic [1:0] l,
                                                input logic [ORD_W-1:0] m);
        logic [SEL_W-1:0] le;
        le = {2'b00, l};
        return SEL_W'(le * le) + le + m;
    endfunction

    // normalisation constants in Q2.30
    function automatic logic [KQ_W-1:0] kq_of(input logic [SEL_W-1:0] sel);
        logic [KQ_W-1:0] k;
        case (sel)
            SEL_00:  k = 32'd302896976;
            SEL_1N1: k = 32'd524632952;
            SEL_10:  k = 32'd524632952;
            SEL_1P1: k = 32'd524632952;
            SEL_2N2: k = 32'd1173114945;
            SEL_2N1: k = 32'd1173114945;
            SEL_20:  k = 32'd338649115;
            SEL_2P1: k = 32'd1173114945;
            SEL_2P2: k = 32'd586557472;
            SEL_3N3: k = 32'd633554480;
            SEL_3N2: k = 32'd3103770403;
            SEL_3N1: k = 32'd490749190;
            SEL_30:  k = 32'd400695036;
            SEL_3P1: k = 32'd490749190;
            SEL_3P2: k = 32'd1551885201;
            SEL_3P3: k = 32'd633554480;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

>>> rtl/shc_in_if.sv
`default_nettype none
interface shc_in_if import shc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [DEG_W-1:0]          degree;
    logic signed [ORD_W-1:0]   order;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [RAD_W-1:0]          radius;

    modport source (output valid, degree, order, coord_x, coord_y, coord_z, radius,
                    input ready);
    modport sink (input valid, degree, order, coord_x, coord_y, coord_z, radius,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/shc_out_if.sv
`default_nettype none
interface shc_out_if import shc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] harmonic_value;
    logic [ST_W-1:0]         status;

    modport source (output valid, harmonic_value, status, input ready);
    modport sink (input valid, harmonic_value, status, output ready);
endinterface
`default_nettype wire

>>> rtl/shc_poly.sv
`default_nettype none
module shc_poly import shc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    shc_in_if.sink     i_in,
    output logic       o_valid,
    input  logic       i_ready,
    output t_poly_word o_word
);

    logic [POLY_ST-1:0] r_v;
    logic [POLY_ST:0]   ld;

    assign ld[POLY_ST] = i_ready;
    for (genvar k = 0; k < POLY_ST; k++) begin : g_ld
        assign ld[k] = ~r_v[k] | ld[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) r_v[0] <= i_in.valid;
            for (int k = 1; k < POLY_ST; k++) begin
                if (ld[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign i_in.ready = ld[0];
    assign o_valid    = r_v[POLY_ST-1];

    // stage 0: decode, squares and cross products
    logic signed [4:0]  w_m, w_l;
    logic               w_unsup, w_zero;
    logic [ST_W-1:0]    r0_pre;
    logic [1:0]         r0_l;
    logic [SEL_W-1:0]   r0_sel;
    logic signed [COORD_W-1:0] r0_x, r0_y, r0_z;
    logic [RAD_W-1:0]   r0_r;
    logic signed [SQ_W-1:0] r0_xx, r0_yy, r0_zz, r0_xy, r0_yz, r0_zx;
    logic [RR_W-1:0]    r0_rr;

    assign w_m     = 5'(i_in.order);
    assign w_l     = signed'({2'b00, i_in.degree});
    assign w_unsup = (i_in.degree > DEG_W'(3)) || (w_m > w_l) || (w_m < -w_l);
    assign w_zero  = (i_in.degree != '0) && (i_in.radius == '0);

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r0_pre <= w_unsup ? ST_UNSUP : (w_zero ? ST_ZERO : ST_OK);
            r0_l   <= i_in.degree[1:0];
            r0_sel <= sel_of(i_in.degree[1:0], i_in.order);
            r0_x   <= i_in.coord_x;
            r0_y   <= i_in.coord_y;
            r0_z   <= i_in.coord_z;
            r0_r   <= i_in.radius;
            r0_xx  <= i_in.coord_x * i_in.coord_x;
            r0_yy  <= i_in.coord_y * i_in.coord_y;
            r0_zz  <= i_in.coord_z * i_in.coord_z;
            r0_xy  <= i_in.coord_x * i_in.coord_y;
            r0_yz  <= i_in.coord_y * i_in.coord_z;
            r0_zx  <= i_in.coord_z * i_in.coord_x;
            r0_rr  <= i_in.radius * i_in.radius;
        end
    end

    // stage 1: quadratic term t and outer factor c, so that P = c * t
    logic signed [T_W-1:0]     exx, eyy, ezz, exy, eyz, ezx;
    logic signed [T_W-1:0]     n1_t;
    logic signed [COORD_W-1:0] n1_c;
    logic [ST_W-1:0]           r1_pre;
    logic [1:0]                r1_l;
    logic [SEL_W-1:0]          r1_sel;
    logic signed [COORD_W-1:0] r1_c;
    logic signed [T_W-1:0]     r1_t;
    logic [RAD_W-1:0]          r1_r;
    logic [RR_W-1:0]           r1_rr;
    logic [RR_W-1:0]           r1_prh, r1_prl;

    assign exx = T_W'(r0_xx);
    assign eyy = T_W'(r0_yy);
    assign ezz = T_W'(r0_zz);
    assign exy = T_W'(r0_xy);
    assign eyz = T_W'(r0_yz);
    assign ezx = T_W'(r0_zx);

    always_comb begin
        n1_c = COORD_W'(1);
        n1_t = T_W'(1);
        case (r0_sel)
            SEL_00:  begin n1_c = COORD_W'(1); n1_t = T_W'(1); end
            SEL_1N1: begin n1_c = r0_y; n1_t = T_W'(1); end
            SEL_10:  begin n1_c = r0_z; n1_t = T_W'(1); end
            SEL_1P1: begin n1_c = r0_x; n1_t = T_W'(1); end
            SEL_2N2: begin n1_c = COORD_W'(1); n1_t = exy; end
            SEL_2N1: begin n1_c = COORD_W'(1); n1_t = eyz; end
            SEL_20:  begin n1_c = COORD_W'(1); n1_t = (ezz <<< 1) - exx - eyy; end
            SEL_2P1: begin n1_c = COORD_W'(1); n1_t = ezx; end
            SEL_2P2: begin n1_c = COORD_W'(1); n1_t = exx - eyy; end
            SEL_3N3: begin n1_c = r0_y; n1_t = (exx <<< 1) + exx - eyy; end
            SEL_3N2: begin n1_c = r0_z; n1_t = exy; end
            SEL_3N1: begin n1_c = r0_y; n1_t = (ezz <<< 2) - exx - eyy; end
            SEL_30:  begin
                n1_c = r0_z;
                n1_t = (ezz <<< 1) - (exx <<< 1) - exx - (eyy <<< 1) - eyy;
            end
            SEL_3P1: begin n1_c = r0_x; n1_t = (ezz <<< 2) - exx - eyy; end
            SEL_3P2: begin n1_c = r0_z; n1_t = exx - eyy; end
            SEL_3P3: begin n1_c = r0_x; n1_t = exx - (eyy <<< 1) - eyy; end
            default: begin n1_c = COORD_W'(1); n1_t = T_W'(1); end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r1_pre <= r0_pre;
            r1_l   <= r0_l;
            r1_sel <= r0_sel;
            r1_c   <= n1_c;
            r1_t   <= n1_t;
            r1_r   <= r0_r;
            r1_rr  <= r0_rr;
            // r cubed in two halves
            r1_prh <= r0_rr[RR_W-1:RAD_W] * r0_r;
            r1_prl <= r0_rr[RAD_W-1:0] * r0_r;
        end
    end

    // stage 2: partial products of c * t, select r^l
    logic [ST_W-1:0]        r2_pre;
    logic [SEL_W-1:0]       r2_sel;
    logic signed [PH_W-1:0] r2_pph;
    logic signed [PL_W-1:0] r2_ppl;
    logic [RL_W-1:0]        r2_rl;
    logic [RL_W-1:0]        n2_rl;

    always_comb begin
        case (r1_l)
            2'd0:    n2_rl = RL_W'(1);
            2'd1:    n2_rl = RL_W'(r1_r);
            2'd2:    n2_rl = RL_W'(r1_rr);
            default: n2_rl = (RL_W'(r1_prh) << RAD_W) + RL_W'(r1_prl);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r2_pre <= r1_pre;
            r2_sel <= r1_sel;
            r2_pph <= r1_c * signed'(r1_t[T_W-1:TL_W]);
            r2_ppl <= r1_c * signed'({1'b0, r1_t[TL_W-1:0]});
            r2_rl  <= n2_rl;
        end
    end

    // stage 3: assemble P
    logic [ST_W-1:0]       r3_pre;
    logic [SEL_W-1:0]      r3_sel;
    logic signed [P_W-1:0] r3_p;
    logic [RL_W-1:0]       r3_rl;

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r3_pre <= r2_pre;
            r3_sel <= r2_sel;
            r3_p   <= (P_W'(r2_pph) <<< TL_W) + P_W'(r2_ppl);
            r3_rl  <= r2_rl;
        end
    end

    // stage 4: sign and magnitude
    logic [ST_W-1:0] r4_pre;
    logic            r4_neg;
    logic [PM_W-1:0] r4_pmag;
    logic [KQ_W-1:0] r4_kq;
    logic [RL_W-1:0] r4_rl;

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r4_pre  <= r3_pre;
            r4_neg  <= r3_p[P_W-1];
            r4_pmag <= r3_p[P_W-1] ? PM_W'(-r3_p) : PM_W'(r3_p);
            r4_kq   <= kq_of(r3_sel);
            r4_rl   <= r3_rl;
        end
    end

    assign o_word.pre  = r4_pre;
    assign o_word.neg  = r4_neg;
    assign o_word.pmag = r4_pmag;
    assign o_word.kq   = r4_kq;
    assign o_word.rl   = r4_rl;

endmodule
`default_nettype wire

>>> rtl/shc_scale.sv
`default_nettype none
module shc_scale import shc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_poly_word  i_word,
    output logic        o_valid,
    input  logic        i_ready,
    output t_scale_word o_word
);

    logic [SCALE_ST-1:0] r_v;
    logic [SCALE_ST:0]   ld;

    assign ld[SCALE_ST] = i_ready;
    for (genvar k = 0; k < SCALE_ST; k++) begin : g_ld
        assign ld[k] = ~r_v[k] | ld[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) r_v[0] <= i_valid;
            for (int k = 1; k < SCALE_ST; k++) begin
                if (ld[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_v[SCALE_ST-1];

    // stage 0: Kq times three slices of |P|
    logic [ST_W-1:0] r0_pre;
    logic            r0_neg;
    logic [MP_W-1:0] r0_m0, r0_m1, r0_m2;
    logic [RL_W-1:0] r0_rl;

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r0_pre <= i_word.pre;
            r0_neg <= i_word.neg;
            r0_m0  <= i_word.kq * i_word.pmag[PS_W-1:0];
            r0_m1  <= i_word.kq * i_word.pmag[2*PS_W-1:PS_W];
            r0_m2  <= i_word.kq * i_word.pmag[PM_W-1:2*PS_W];
            r0_rl  <= i_word.rl;
        end
    end

    // stage 1: numerator
    logic [ST_W-1:0] r1_pre;
    logic            r1_neg;
    logic [N_W-1:0]  r1_n;
    logic [RL_W-1:0] r1_rl;

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r1_pre <= r0_pre;
            r1_neg <= r0_neg;
            r1_n   <= (N_W'(r0_m2) << (2 * PS_W)) + (N_W'(r0_m1) << PS_W) + N_W'(r0_m0);
            r1_rl  <= r0_rl;
        end
    end

    // stage 2: rounding form, floor((2N + D) / 2D)
    logic [ST_W-1:0] r2_pre;
    logic            r2_neg;
    logic [A_W-1:0]  r2_a;
    logic [B_W-1:0]  r2_b;

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r2_pre <= r1_pre;
            r2_neg <= r1_neg;
            r2_a   <= (A_W'(r1_n) << 1) + (A_W'(r1_rl) << DSH);
            r2_b   <= B_W'(r1_rl) << (DSH + 1);
        end
    end

    assign o_word.pre = r2_pre;
    assign o_word.neg = r2_neg;
    assign o_word.a   = r2_a;
    assign o_word.b   = r2_b;

endmodule
`default_nettype wire

>>> rtl/shc_div.sv
`default_nettype none
module shc_div import shc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_scale_word        i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [OUT_W-1:0] o_value,
    output logic [ST_W-1:0]    o_status
);

    logic [DIV_ST-1:0] r_v;
    logic [DIV_ST:0]   ld;

    assign ld[DIV_ST] = i_ready;
    for (genvar k = 0; k < DIV_ST; k++) begin : g_ld
        assign ld[k] = ~r_v[k] | ld[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) r_v[0] <= i_valid;
            for (int k = 1; k < DIV_ST; k++) begin
                if (ld[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_v[DIV_ST-1];

    t_div_lane r_ln [0:Q_W];
    t_div_lane n_ln [0:Q_W];

    // entry: flag quotients that cannot fit before any step
    always_comb begin
        n_ln[0].pre = i_word.pre;
        n_ln[0].neg = i_word.neg;
        n_ln[0].ovf = i_word.a >= (A_W'(i_word.b) << Q_W);
        n_ln[0].b   = i_word.b;
        n_ln[0].rem = i_word.a;
        n_ln[0].q   = '0;
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        localparam int J = Q_W - k;
        logic [A_W-1:0] w_dv;
        logic           w_ge;
        assign w_dv = A_W'(r_ln[k-1].b) << J;
        assign w_ge = r_ln[k-1].rem >= w_dv;
        always_comb begin
            n_ln[k]     = r_ln[k-1];
            n_ln[k].rem = w_ge ? r_ln[k-1].rem - w_dv : r_ln[k-1].rem;
            n_ln[k].q   = r_ln[k-1].q | (w_ge ? (Q_W'(1) << J) : '0);
        end
    end

    for (genvar k = 0; k <= Q_W; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (ld[k]) r_ln[k] <= n_ln[k];
        end
    end

    // final stage: sign, saturate, special cases
    t_div_lane                w_f;
    logic                     w_sat;
    logic signed [OUT_W-1:0]  w_val;
    logic signed [OUT_W-1:0]  n_val;
    logic [ST_W-1:0]          n_st;
    logic signed [OUT_W-1:0]  r_val;
    logic [ST_W-1:0]          r_st;

    assign w_f = r_ln[Q_W];

    always_comb begin
        if (w_f.neg) begin
            w_sat = w_f.ovf || (w_f.q > (Q_W'(1) << (OUT_W - 1)));
            w_val = w_sat ? {1'b1, {(OUT_W-1){1'b0}}} : signed'(OUT_W'(-w_f.q));
        end else begin
            w_sat = w_f.ovf || w_f.q[Q_W-1];
            w_val = w_sat ? {1'b0, {(OUT_W-1){1'b1}}} : signed'(OUT_W'(w_f.q));
        end
        if (w_f.pre != ST_OK) begin
            n_val = '0;
            n_st  = w_f.pre;
        end else begin
            n_val = w_val;
            n_st  = w_sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[DIV_ST-1]) begin
            r_val <= n_val;
            r_st  <= n_st;
        end
    end

    assign o_value  = r_val;
    assign o_status = r_st;

endmodule
`default_nettype wire

>>> rtl/real_spherical_harmonic_cartesian_unit.sv
// Pipeline of 5 polynomial, 3 scaling and 26 divider stages (an entry stage,
// one stage for each of the 24 quotient bits and an output stage).
// Throughput: one word per cycle unless the output stalls; each stage stalls only when it is
// full and the stage after it stalls too, so bubbles close up under back-pressure.
// Reset: synchronous, active low; clears all stage valid bits, data unreset.
`default_nettype none
module real_spherical_harmonic_cartesian_unit import shc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    shc_in_if.sink     i_in,
    shc_out_if.source  o_out
);

    logic        w_pv, w_pr;
    t_poly_word  w_pw;
    logic        w_sv, w_sr;
    t_scale_word w_sw;

    shc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_pv),
        .i_ready (w_pr),
        .o_word  (w_pw)
    );

    shc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pv),
        .o_ready (w_pr),
        .i_word  (w_pw),
        .o_valid (w_sv),
        .i_ready (w_sr),
        .o_word  (w_sw)
    );

    shc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_sv),
        .o_ready  (w_sr),
        .i_word   (w_sw),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_value  (o_out.harmonic_value),
        .o_status (o_out.status)
    );

endmodule
`default_nettype wire

>>> rtl/shc_checker.sv
`default_nettype none
module shc_checker import shc_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    i_ready,
    input logic signed [OUT_W-1:0] i_value,
    input logic [ST_W-1:0]         i_status
);

    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_UNSUP) |-> i_value == '0)
        else $error("unsupported word carries a nonzero value");

    a_radius_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_ZERO) |-> i_value == '0)
        else $error("zero-radius word carries a nonzero value");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_SAT) |->
            (i_value == {1'b0, {(OUT_W-1){1'b1}}}) ||
            (i_value == {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("saturated word not at a bound");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_value) && $stable(i_status))
        else $error("stalled result word changed");

endmodule

bind real_spherical_harmonic_cartesian_unit shc_checker u_shc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_value  (o_out.harmonic_value),
    .i_status (o_out.status)
);
`default_nettype wire
